FILE: hdl/assert_macros.svh
// Assertion helpers for the LRU write-back record cache.
// Used by files that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LWRC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define LWRC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: hdl/lwrc_pkg.sv
// Shared sizes, codes, token types and helpers of the LRU write-back record cache.
// No dependencies; used by lwrc_cell and lru_writeback_record_cache.
`default_nettype none

package lwrc_pkg;

   // Geometry
   localparam int ENTRIES = 10;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int KEY_W   = 8;
   localparam int STAMP_W = 32;
   localparam int SLOT_W  = 4;
   localparam int FCNT_W  = 4;
   localparam int KIND_W  = 2;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [STAMP_W-1:0] stamp_type;

   // Request opcodes
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // Result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ACCESS    = 2'd0,
      KIND_WRITEBACK = 2'd1,
      KIND_DONE      = 2'd2
   } kind_type;

   // Token that walks the cell chain, one cell per cycle unless the result side stalls
   typedef struct packed {
      logic      valid;
      logic      flush;
      key_type   subject;
      key_type   message;
      stamp_type stamp;
      logic      hit;
      idx_type   hit_idx;
      logic      min_any;
      stamp_type min_stamp;
      idx_type   min_idx;
      logic      min_dirty;
      key_type   min_subject;
      key_type   min_message;
      cnt_type   count;
   } probe_type;

   // Write-back beat raised by a dirty cell while a flush token passes
   typedef struct packed {
      logic    valid;
      idx_type idx;
      key_type subject;
      key_type message;
   } emit_type;

   // Update broadcast to the cells when an access finishes
   typedef struct packed {
      logic      valid;
      idx_type   idx;
      logic      write_key;
      key_type   subject;
      key_type   message;
      stamp_type stamp;
   } commit_type;

   // Fit a slot index into the result field
   function automatic logic [SLOT_W-1:0] to_slot(input idx_type idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

   // Fit a flush count into the result field
   function automatic logic [FCNT_W-1:0] to_fcnt(input cnt_type cnt);
      logic [CNT_W+FCNT_W-1:0] wide;
      wide = {{FCNT_W{1'b0}}, cnt};
      return wide[FCNT_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: hdl/lru_writeback_record_cache.sv
// Top level of the LRU write-back record cache: chain of slot cells, tail stage,
// access counter and result register. Depends on lwrc_pkg, lwrc_cell, assert_macros.svh.
`default_nettype none

// Fully associative cache of ENTRIES record keys with least-recently-used
// replacement and dirty marks. Each request launches a token into a chain of
// slot cells; the token moves one cell per cycle while the result side does
// not stall, and one more item can be accepted in the cycle after its final
// result beat is loaded. A stalled result beat holds the token in place. An
// access gives one beat with the slot used and, on a miss that evicts a dirty
// key, that key for write-back. A flush gives one write-back beat per dirty
// slot, in slot order, as the token passes it, then a done beat with the
// count. The last result beat of every request has last set.

module lru_writeback_record_cache (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_op,
   input  wire logic [lwrc_pkg::KEY_W-1:0] req_subject,
   input  wire logic [lwrc_pkg::KEY_W-1:0] req_message,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [lwrc_pkg::KIND_W-1:0]     rsp_kind,
   output logic                            rsp_hit,
   output logic [lwrc_pkg::SLOT_W-1:0]     rsp_slot,
   output logic                            rsp_writeback_valid,
   output logic [lwrc_pkg::KEY_W-1:0]      rsp_writeback_subject,
   output logic [lwrc_pkg::KEY_W-1:0]      rsp_writeback_message,
   output logic [lwrc_pkg::FCNT_W-1:0]     rsp_flushed_count,
   output logic                            rsp_last
);

`include "assert_macros.svh"

   localparam int N = lwrc_pkg::ENTRIES;

   logic                 busy_ff, busy_in;
   lwrc_pkg::stamp_type  count_ff, count_in;
   lwrc_pkg::probe_type  tail_ff, tail_in;
   lwrc_pkg::probe_type  launch;
   lwrc_pkg::probe_type  probe_out [N];
   lwrc_pkg::emit_type   emit_out [N];
   lwrc_pkg::emit_type   emit_any;
   lwrc_pkg::commit_type commit;
   logic [N-1:0]         probe_vld;
   logic                 req_accept;
   logic                 advance;
   logic                 finish;

   // Result register
   logic                          rsp_valid_ff, rsp_valid_in;
   lwrc_pkg::kind_type            kind_ff, kind_in;
   logic                          hit_ff, hit_in;
   logic [lwrc_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic                          wbv_ff, wbv_in;
   lwrc_pkg::key_type             wbs_ff, wbs_in;
   lwrc_pkg::key_type             wbm_ff, wbm_in;
   logic [lwrc_pkg::FCNT_W-1:0]   fcnt_ff, fcnt_in;
   logic                          last_ff, last_in;
   logic                          load_beat;

   assign req_ready  = !busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign finish     = advance && tail_ff.valid;

   // Build the token for a new request
   always_comb begin
      launch         = '0;
      launch.valid   = req_accept;
      launch.flush   = (req_op == lwrc_pkg::OP_FLUSH);
      launch.subject = req_subject;
      launch.message = req_message;
      launch.stamp   = count_ff + lwrc_pkg::STAMP_W'(1);
   end

   // Chain of slot cells
   for (genvar k = 0; k < N; k++) begin : g_cell
      lwrc_pkg::probe_type prev;
      logic                shift;
      if (k == 0) begin : g_head
         assign prev  = launch;
         assign shift = advance || req_accept;
      end else begin : g_body
         assign prev  = probe_out[k-1];
         assign shift = advance;
      end
      lwrc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (lwrc_pkg::IDX_W'(k)),
         .shift     (shift),
         .probe_in  (prev),
         .commit    (commit),
         .probe_out (probe_out[k]),
         .emit_out  (emit_out[k])
      );
      assign probe_vld[k] = probe_out[k].valid;
   end

   // Merge write-back requests; at most one cell holds the token
   always_comb begin
      emit_any = '0;
      for (int k = 0; k < N; k++) begin
         emit_any = emit_any | emit_out[k];
      end
   end

   // Update the chosen slot when an access leaves the tail
   always_comb begin
      commit           = '0;
      commit.valid     = finish && !tail_ff.flush;
      commit.idx       = tail_ff.hit ? tail_ff.hit_idx : tail_ff.min_idx;
      commit.write_key = !tail_ff.hit;
      commit.subject   = tail_ff.subject;
      commit.message   = tail_ff.message;
      commit.stamp     = tail_ff.stamp;
   end

   // Advance tail, busy flag and access counter
   always_comb begin
      tail_in  = advance ? probe_out[N-1] : tail_ff;
      busy_in  = busy_ff;
      count_in = count_ff;
      if (req_accept) begin
         busy_in = 1'b1;
         if (req_op == lwrc_pkg::OP_ACCESS) begin
            count_in = count_ff + lwrc_pkg::STAMP_W'(1);
         end
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   // Assemble the next result beat
   always_comb begin
      load_beat    = advance && (emit_any.valid || tail_ff.valid);
      rsp_valid_in = load_beat || (rsp_valid_ff && !rsp_ready);
      kind_in      = kind_ff;
      hit_in       = hit_ff;
      slot_in      = slot_ff;
      wbv_in       = wbv_ff;
      wbs_in       = wbs_ff;
      wbm_in       = wbm_ff;
      fcnt_in      = fcnt_ff;
      last_in      = last_ff;
      if (load_beat) begin
         kind_in = lwrc_pkg::KIND_WRITEBACK;
         hit_in  = 1'b0;
         slot_in = lwrc_pkg::to_slot(emit_any.idx);
         wbv_in  = 1'b1;
         wbs_in  = emit_any.subject;
         wbm_in  = emit_any.message;
         fcnt_in = '0;
         last_in = 1'b0;
         if (tail_ff.valid) begin
            last_in = 1'b1;
            if (tail_ff.flush) begin
               kind_in = lwrc_pkg::KIND_DONE;
               slot_in = '0;
               wbv_in  = 1'b0;
               wbs_in  = '0;
               wbm_in  = '0;
               fcnt_in = lwrc_pkg::to_fcnt(tail_ff.count);
            end else begin
               kind_in = lwrc_pkg::KIND_ACCESS;
               hit_in  = tail_ff.hit;
               slot_in = lwrc_pkg::to_slot(commit.idx);
               wbv_in  = !tail_ff.hit && tail_ff.min_dirty;
               wbs_in  = wbv_in ? tail_ff.min_subject : '0;
               wbm_in  = wbv_in ? tail_ff.min_message : '0;
            end
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      hit_ff  <= hit_in;
      slot_ff <= slot_in;
      wbv_ff  <= wbv_in;
      wbs_ff  <= wbs_in;
      wbm_ff  <= wbm_in;
      fcnt_ff <= fcnt_in;
      last_ff <= last_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = kind_ff;
   assign rsp_hit               = hit_ff;
   assign rsp_slot              = slot_ff;
   assign rsp_writeback_valid   = wbv_ff;
   assign rsp_writeback_subject = wbs_ff;
   assign rsp_writeback_message = wbm_ff;
   assign rsp_flushed_count     = fcnt_ff;
   assign rsp_last              = last_ff;

   // Checks
   `LWRC_ASSERT_ALWAYS(a_one_token, $countones({tail_ff.valid, probe_vld}) <= 1, "tokens collide")
   `LWRC_ASSERT(a_idle_empty, !busy_ff |-> (probe_vld == '0) && !tail_ff.valid, "stray token")
   `LWRC_ASSERT(a_no_beat_clash, !(emit_any.valid && tail_ff.valid), "beats collide")
   `LWRC_ASSERT(a_finish_frees, finish |=> !busy_ff, "block stays busy after final beat")

endmodule

`default_nettype wire

FILE: hdl/lwrc_cell.sv
// One cache slot: key, use stamp and dirty mark, plus the token stage that
// holds the probe passing through. Depends on lwrc_pkg.
`default_nettype none

module lwrc_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lwrc_pkg::idx_type   cell_idx,
   input  wire logic                shift,
   input  wire lwrc_pkg::probe_type probe_in,
   input  wire lwrc_pkg::commit_type commit,
   output lwrc_pkg::probe_type      probe_out,
   output lwrc_pkg::emit_type       emit_out
);

   lwrc_pkg::probe_type probe_ff, probe_in_next;
   lwrc_pkg::key_type   subject_ff, subject_in;
   lwrc_pkg::key_type   message_ff, message_in;
   lwrc_pkg::stamp_type stamp_ff, stamp_in;
   logic                dirty_ff, dirty_in;
   logic                match;
   logic                older;
   logic                mine;

   // Compare this slot against the token
   assign match = (stamp_ff != '0) && (subject_ff == probe_ff.subject)
                  && (message_ff == probe_ff.message);
   assign older = !probe_ff.min_any || (stamp_ff < probe_ff.min_stamp);
   assign mine  = commit.valid && (commit.idx == cell_idx);

   // Fold this slot into the token, raise a write-back on flush
   always_comb begin
      probe_out = probe_ff;
      emit_out  = '0;
      if (probe_ff.valid) begin
         if (probe_ff.flush) begin
            if (dirty_ff) begin
               emit_out.valid   = 1'b1;
               emit_out.idx     = cell_idx;
               emit_out.subject = subject_ff;
               emit_out.message = message_ff;
               probe_out.count  = probe_ff.count + lwrc_pkg::CNT_W'(1);
            end
         end else begin
            if (!probe_ff.hit && match) begin
               probe_out.hit     = 1'b1;
               probe_out.hit_idx = cell_idx;
            end
            if (older) begin
               probe_out.min_any     = 1'b1;
               probe_out.min_stamp   = stamp_ff;
               probe_out.min_idx     = cell_idx;
               probe_out.min_dirty   = dirty_ff;
               probe_out.min_subject = subject_ff;
               probe_out.min_message = message_ff;
            end
         end
      end
   end

   // Next slot contents: commit from the tail, clear mark as flush passes
   always_comb begin
      probe_in_next = shift ? probe_in : probe_ff;
      subject_in    = subject_ff;
      message_in    = message_ff;
      stamp_in      = stamp_ff;
      dirty_in      = dirty_ff;
      if (mine) begin
         stamp_in = commit.stamp;
         dirty_in = 1'b1;
         if (commit.write_key) begin
            subject_in = commit.subject;
            message_in = commit.message;
         end
      end else if (shift && emit_out.valid) begin
         dirty_in = 1'b0;
      end
   end

   // Hold slot control state
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
         stamp_ff <= '0;
         dirty_ff <= 1'b0;
      end else begin
         probe_ff <= probe_in_next;
         stamp_ff <= stamp_in;
         dirty_ff <= dirty_in;
      end
   end

   // Hold key payload
   always_ff @(posedge clock) begin
      subject_ff <= subject_in;
      message_ff <= message_in;
   end

endmodule

`default_nettype wire
